// ===== rtl/pcpbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpbs_pkg
// Shared types, codes and helpers of the PC power button sequencer.
// ----------------------------------------------------------------------------
package pcpbs_pkg;

  // Timer and register widths
  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_val_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_BOOT_HOLD     = 3'd0;
  localparam cfg_idx_t REG_SHUTDOWN_HOLD = 3'd1;
  localparam cfg_idx_t REG_STANDBY_HOLD  = 3'd2;
  localparam cfg_idx_t REG_STANDBY_WAIT  = 3'd3;
  localparam cfg_idx_t REG_STARTUP_WAIT  = 3'd4;
  localparam cfg_idx_t REG_SHUTDOWN_WAIT = 3'd5;
  localparam cfg_idx_t REG_CYCLE         = 3'd6;

  // Request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_PAUSE = 2'd3;

  // Action lock codes
  localparam logic [1:0] LOCK_NONE    = 2'd0;
  localparam logic [1:0] LOCK_START   = 2'd1;
  localparam logic [1:0] LOCK_STOP    = 2'd2;
  localparam logic [1:0] LOCK_STANDBY = 2'd3;

  typedef struct packed {
    cfg_val_t boot_hold;
    cfg_val_t shutdown_hold;
    cfg_val_t standby_hold;
    cfg_val_t standby_wait;
    cfg_val_t startup_wait;
    cfg_val_t shutdown_wait;
    cfg_val_t cycle;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ignition_level;
    logic       pc_running;
  } item_t;

  typedef struct packed {
    logic       power_button;
    logic       display_button;
    logic [1:0] action_state;
  } result_t;

  // Saturating tick count
  function automatic timer_t timer_inc(timer_t t);
    timer_inc = (t == '1) ? t : t + timer_t'(1);
  endfunction

  // Elapsed-ticks check against a register value
  function automatic logic timer_ge(timer_t t, cfg_val_t v);
    timer_ge = (CMP_W'(t) >= CMP_W'(v));
  endfunction

endpackage

// ===== rtl/pcpbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pcpbs_cfg_regs
// Hold times, wait times and cycle period, written through the config port.
// ----------------------------------------------------------------------------
module pcpbs_cfg_regs
  import pcpbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  cfg_idx_t cfg_idx_i,
  input  cfg_val_t cfg_data_i,
  output cfg_t     cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOOT_HOLD:     cfg_d.boot_hold     = cfg_data_i;
        REG_SHUTDOWN_HOLD: cfg_d.shutdown_hold = cfg_data_i;
        REG_STANDBY_HOLD:  cfg_d.standby_hold  = cfg_data_i;
        REG_STANDBY_WAIT:  cfg_d.standby_wait  = cfg_data_i;
        REG_STARTUP_WAIT:  cfg_d.startup_wait  = cfg_data_i;
        REG_SHUTDOWN_WAIT: cfg_d.shutdown_wait = cfg_data_i;
        REG_CYCLE:         cfg_d.cycle         = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boot_hold     <= cfg_val_t'(500);
      cfg_q.shutdown_hold <= cfg_val_t'(500);
      cfg_q.standby_hold  <= cfg_val_t'(100);
      cfg_q.standby_wait  <= cfg_val_t'(5000);
      cfg_q.startup_wait  <= cfg_val_t'(30000);
      cfg_q.shutdown_wait <= cfg_val_t'(30000);
      cfg_q.cycle         <= cfg_val_t'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pcpbs_core.sv =====
// ----------------------------------------------------------------------------
// pcpbs_core
// Sequencer state and the per-tick update: press timing, commands, sampling.
// ----------------------------------------------------------------------------
module pcpbs_core
  import pcpbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [1:0] lock_q, lock_d;
  logic       start_q, start_d;
  logic       stop_q, stop_d;
  logic       pwait_q, pwait_d;
  logic       phold_q, phold_d;
  timer_t     press_q, press_d;
  timer_t     trans_q, trans_d;
  timer_t     cyc_q, cyc_d;
  logic       ign_smp_q, ign_smp_d;
  logic       last_ign_q, last_ign_d;
  logic       run_smp_q, run_smp_d;
  logic       first_q, first_d;

  // One tick of the sequencer
  always_comb begin
    lock_d     = lock_q;
    start_d    = start_q;
    stop_d     = stop_q;
    pwait_d    = pwait_q;
    phold_d    = phold_q;
    ign_smp_d  = ign_smp_q;
    last_ign_d = last_ign_q;
    run_smp_d  = run_smp_q;
    first_d    = first_q;

    // Advance the timers
    press_d = timer_inc(press_q);
    trans_d = timer_inc(trans_q);
    cyc_d   = timer_inc(cyc_q);

    // Start on the first tick if ignition is on and the PC is off
    if (first_q) begin
      if (!item_i.pc_running && !item_i.ignition_level && !start_d &&
          lock_d == LOCK_NONE) begin
        start_d = 1'b1;
        lock_d  = LOCK_START;
        press_d = '0;
      end
      first_d = 1'b0;
    end

    // Release presses whose hold time has run out
    if (start_d && timer_ge(press_d, cfg_i.boot_hold)) begin
      start_d = 1'b0;
      press_d = '0;
      trans_d = '0;
    end
    if (stop_d && timer_ge(press_d, cfg_i.shutdown_hold)) begin
      stop_d  = 1'b0;
      press_d = '0;
      trans_d = '0;
    end
    if (pwait_d && timer_ge(press_d, cfg_i.standby_wait)) begin
      pwait_d = 1'b0;
      trans_d = '0;
    end
    if (phold_d && timer_ge(press_d, cfg_i.standby_hold)) begin
      phold_d = 1'b0;
      pwait_d = 1'b1;
      press_d = '0;
    end

    // Commands, gated by the lock and the sampled PC state
    case (item_i.req_type)
      REQ_START: begin
        if (!start_d && !run_smp_d && lock_d == LOCK_NONE) begin
          start_d = 1'b1;
          lock_d  = LOCK_START;
          press_d = '0;
        end
      end
      REQ_STOP: begin
        if (!stop_d && run_smp_d && lock_d == LOCK_NONE) begin
          stop_d  = 1'b1;
          lock_d  = LOCK_STOP;
          press_d = '0;
        end
      end
      REQ_PAUSE: begin
        if (!pwait_d && !phold_d && run_smp_d && lock_d == LOCK_NONE) begin
          lock_d  = LOCK_STANDBY;
          phold_d = 1'b1;
          press_d = '0;
        end
      end
      default: ;
    endcase

    // Periodic pin sampling and lock check while nothing is in progress
    if (timer_ge(cyc_d, cfg_i.cycle) && !(start_d || stop_d || pwait_d || phold_d)) begin
      ign_smp_d = item_i.ignition_level;
      run_smp_d = item_i.pc_running;
      if (ign_smp_d != last_ign_d && !ign_smp_d && !run_smp_d &&
          lock_d == LOCK_NONE) begin
        start_d = 1'b1;
        lock_d  = LOCK_START;
        press_d = '0;
      end
      last_ign_d = ign_smp_d;
      cyc_d      = '0;
      case (lock_d)
        LOCK_STOP:    if (timer_ge(trans_d, cfg_i.shutdown_wait)) lock_d = LOCK_NONE;
        LOCK_START:   if (timer_ge(trans_d, cfg_i.startup_wait))  lock_d = LOCK_NONE;
        LOCK_STANDBY: if (timer_ge(trans_d, cfg_i.standby_wait))  lock_d = LOCK_NONE;
        default: ;
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    result_o.power_button   = start_d || stop_d || phold_d;
    result_o.display_button = phold_d;
    result_o.action_state   = lock_d;
  end

  // Commit state on an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q     <= LOCK_NONE;
      start_q    <= 1'b0;
      stop_q     <= 1'b0;
      pwait_q    <= 1'b0;
      phold_q    <= 1'b0;
      press_q    <= '0;
      trans_q    <= '0;
      cyc_q      <= '0;
      ign_smp_q  <= 1'b1;
      last_ign_q <= 1'b1;
      run_smp_q  <= 1'b0;
      first_q    <= 1'b1;
    end else if (fire_i) begin
      lock_q     <= lock_d;
      start_q    <= start_d;
      stop_q     <= stop_d;
      pwait_q    <= pwait_d;
      phold_q    <= phold_d;
      press_q    <= press_d;
      trans_q    <= trans_d;
      cyc_q      <= cyc_d;
      ign_smp_q  <= ign_smp_d;
      last_ign_q <= last_ign_d;
      run_smp_q  <= run_smp_d;
      first_q    <= first_d;
    end
  end

endmodule

// ===== rtl/pc_power_button_sequencer.sv =====
// ----------------------------------------------------------------------------
// pc_power_button_sequencer
// Host-PC power sequencer driven by one tick item per millisecond.
// ----------------------------------------------------------------------------
// Each accepted tick item yields exactly one result item. An item passes an
// input register and then the sequencer update, which writes the result
// register once the result side is free; the block takes one item every clock
// cycle as long as the result side keeps up, and the state registers are
// updated once for each item that is taken.
// Configuration registers may be written only while no item is in flight.
module pc_power_button_sequencer
  import pcpbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_idx_t   cfg_idx_i,
  input  cfg_val_t   cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic       ignition_level_i,
  input  logic       pc_running_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       power_button_o,
  output logic       display_button_o,
  output logic [1:0] action_state_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t result;
  result_t out_q;
  logic    out_valid_q;
  logic    out_load;
  logic    fire;
  logic    in_load;

  // Handshake: the result register frees up when empty or taken
  assign out_load   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_load;
  assign in_load    = !in_valid_q || out_load;
  assign in_stall_o = !in_load;

  pcpbs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      item_q.req_type       <= req_type_i;
      item_q.ignition_level <= ignition_level_i;
      item_q.pc_running     <= pc_running_i;
    end
  end

  pcpbs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign power_button_o   = out_q.power_button;
  assign display_button_o = out_q.display_button;
  assign action_state_o   = out_q.action_state;

endmodule

// ===== rtl/pcpbs_checker.sv =====
// ----------------------------------------------------------------------------
// pcpbs_checker
// Port-level checks of the power button sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pcpbs_checker
  import pcpbs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       power_button_o,
  input logic       display_button_o,
  input logic [1:0] action_state_o
);

  // A pause press drives both buttons
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && display_button_o) |-> power_button_o)
    else $error("display button pressed without power button");

  // A pause press always runs under the standby lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && display_button_o) |-> (action_state_o == LOCK_STANDBY))
    else $error("display button pressed outside standby lock");

  // Input backs up only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side is free");

  // A stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(power_button_o) && $stable(display_button_o) &&
       $stable(action_state_o)))
    else $error("stalled result item changed");

endmodule

bind pc_power_button_sequencer pcpbs_checker u_pcpbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .power_button_o   (power_button_o),
  .display_button_o (display_button_o),
  .action_state_o   (action_state_o)
);
